@@ sv/mefc_pkg.sv @@
// package for the multichannel edge frequency counter: codes, widths and constants
`default_nettype none

package mefc_pkg;

  localparam int unsigned SlotsDef  = 8;
  localparam int unsigned MaxSlots  = 8;
  localparam int unsigned PinW      = 5;
  localparam int unsigned LvlW      = 32;
  localparam int unsigned TickW     = 32;
  localparam int unsigned CntW      = 32;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned MaskW     = 32;
  localparam int unsigned MapW      = 40;
  localparam int unsigned CfgW      = 40;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned ConstW    = 20;
  localparam int unsigned ProdW     = CntW + ConstW;
  localparam int unsigned DivSteps  = ProdW;
  localparam int unsigned StepW     = $clog2(DivSteps);
  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 96;

  localparam logic [ConstW-1:0] UsecPerSec = ConstW'(1000000);

  localparam logic [CfgIdxW-1:0] CfgChanMask = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPinMap   = 1'b1;

  typedef enum logic [1:0] {
    FuncStart  = 2'd0,
    FuncSample = 2'd1,
    FuncRead   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StOut
  } state_e;

endpackage

`default_nettype wire

@@ sv/multichannel_edge_frequency_counter_unit.sv @@
// top level: per-slot rising edge counters with an iterative frequency divider
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tuser: func; tdata: level, tick, slot
//  m_axis    out  m_axis_tvalid/tready        tdata: count, period, freq; tuser: wrapped
//  cfg       in   cfg_we_i (no back-pressure) cfg_idx_i, cfg_data_i
//
// start and sample requests are taken in the idle state, so samples can arrive every cycle
// while no read is in progress. a read request holds s_axis_tready low after acceptance
// through the multiply by 10^6, the one-bit-a-cycle restoring divider and the load of
// the output register; the last step waits while a previous result is untaken.
// reset clears configuration, slot counters, ticks, levels and the armed flag.
// the output register lets starts and samples carry on while a result waits.
`default_nettype none

module multichannel_edge_frequency_counter_unit #(
  parameter int unsigned Slots = mefc_pkg::SlotsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [mefc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mefc_pkg::CfgW-1:0]      cfg_data_i,
  // request stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: level [31:0], tick [63:32], slot [66:64], zero fill [71:67]
  input  wire logic [mefc_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: func [1:0]
  input  wire logic [1:0]                     s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: edge_count [31:0], period_ticks [63:32], frequency_hz [95:64]
  output logic [mefc_pkg::OutDataW-1:0]       m_axis_tdata,
  // tuser: wrapped [0]
  output logic                                m_axis_tuser
);

  import mefc_pkg::*;

  // request fields
  logic [LvlW-1:0]  req_lvl;
  logic [TickW-1:0] req_tick;
  logic [SlotW-1:0] req_slot;
  func_e            req_func;
  logic             req_acc;

  assign req_lvl  = s_axis_tdata[LvlW-1:0];
  assign req_tick = s_axis_tdata[LvlW+TickW-1:LvlW];
  assign req_slot = s_axis_tdata[LvlW+TickW+SlotW-1:LvlW+TickW];
  assign req_func = func_e'(s_axis_tuser);
  assign req_acc  = s_axis_tvalid && s_axis_tready;

  // configuration
  logic [MaskW-1:0] chan_mask_q;
  logic [MapW-1:0]  pin_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_mask_q <= '0;
      pin_map_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgChanMask: chan_mask_q <= cfg_data_i[MaskW-1:0];
        CfgPinMap:   pin_map_q   <= cfg_data_i[MapW-1:0];
        default: ;
      endcase
    end
  end

  // measurement state
  logic [CntW-1:0]  edge_cnt_q [Slots];
  logic [CntW-1:0]  edge_cnt_d [Slots];
  logic [LvlW-1:0]  prev_lvl_q;
  logic [TickW-1:0] first_tick_q, last_tick_q;
  logic             armed_q;

  logic [LvlW-1:0]  prev_eff;
  logic [LvlW-1:0]  rising;
  logic             do_start, do_sample, do_read;

  assign do_start  = req_acc && (req_func == FuncStart);
  assign do_sample = req_acc && (req_func == FuncSample);
  assign do_read   = req_acc && (req_func == FuncRead);

  // the first sample after a start sees itself as previous level, so no edges
  assign prev_eff = armed_q ? prev_lvl_q : req_lvl;
  assign rising   = ~prev_eff & req_lvl & chan_mask_q;

  always_comb begin
    for (int s = 0; s < Slots; s++) begin
      edge_cnt_d[s] = edge_cnt_q[s];
      if (do_start) begin
        edge_cnt_d[s] = '0;
      end else if (do_sample && rising[pin_map_q[PinW*s +: PinW]] &&
                   (edge_cnt_q[s] != {CntW{1'b1}})) begin
        edge_cnt_d[s] = edge_cnt_q[s] + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Slots; s++) begin
        edge_cnt_q[s] <= '0;
      end
      prev_lvl_q   <= '0;
      first_tick_q <= '0;
      last_tick_q  <= '0;
      armed_q      <= 1'b0;
    end else begin
      for (int s = 0; s < Slots; s++) begin
        edge_cnt_q[s] <= edge_cnt_d[s];
      end
      if (do_start) begin
        armed_q <= 1'b0;
      end else if (do_sample) begin
        if (!armed_q) begin
          first_tick_q <= req_tick;
        end
        armed_q     <= 1'b1;
        prev_lvl_q  <= req_lvl;
        last_tick_q <= req_tick;
      end
    end
  end

  // read snapshot
  logic [CntW-1:0]  cnt_sel;
  logic [TickW-1:0] diff_ticks;
  logic [TickW-1:0] per_sel;

  always_comb begin
    cnt_sel = '0;
    for (int s = 0; s < Slots; s++) begin
      if (req_slot == SlotW'(s)) begin
        cnt_sel = edge_cnt_q[s];
      end
    end
  end

  assign diff_ticks = last_tick_q - first_tick_q;
  assign per_sel    = (diff_ticks == '0) ? TickW'(1) : diff_ticks;

  // sequencer
  state_e state_q, state_d;
  logic   out_free;
  logic   load_out;
  logic [StepW-1:0] step_q;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (do_read) state_d = StMul;
      StMul:  state_d = StDiv;
      StDiv:  if (step_q == StepW'(DivSteps - 1)) state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      StIdle:  s_axis_tready = 1'b1;
      StOut:   load_out      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StDiv) begin
        step_q <= step_q + StepW'(1);
      end else begin
        step_q <= '0;
      end
    end
  end

  // shared datapath: multiply once, then restoring divide one bit a cycle
  logic [CntW-1:0]  rd_cnt_q;
  logic [TickW-1:0] period_q;
  logic             wrap_q;
  logic [ProdW-1:0] dq_q;
  logic [TickW-1:0] rem_q;
  logic [TickW:0]   trial;
  logic             trial_ge;

  assign trial    = {rem_q, dq_q[ProdW-1]};
  assign trial_ge = trial >= {1'b0, period_q};

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (do_read) begin
          rd_cnt_q <= cnt_sel;
          period_q <= per_sel;
          wrap_q   <= last_tick_q < first_tick_q;
        end
      end
      StMul: begin
        dq_q  <= ProdW'(rd_cnt_q) * ProdW'(UsecPerSec);
        rem_q <= '0;
      end
      StDiv: begin
        rem_q <= trial_ge ? TickW'(trial - {1'b0, period_q}) : trial[TickW-1:0];
        dq_q  <= {dq_q[ProdW-2:0], trial_ge};
      end
      default: ;
    endcase
  end

  // output register
  logic [CntW-1:0] freq_sat;

  assign freq_sat = (|dq_q[ProdW-1:CntW]) ? {CntW{1'b1}} : dq_q[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_axis_tdata <= {freq_sat, period_q, rd_cnt_q};
      m_axis_tuser <= wrap_q;
    end
  end

  // checks
  a_read_starts_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_read |=> state_q == StMul)
    else $error("read request did not start the multiply step");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < period_q))
    else $error("divider remainder not below period");

  a_div_full_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && $past(state_q) == StDiv) |->
      ($past(step_q) == StepW'(DivSteps - 1)))
    else $error("divider left before all quotient bits");

  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready)
    else $error("request taken while a read is in progress");

endmodule

`default_nettype wire
